### design/cbra_pkg.sv
// ----------------------------------------------------------------------------
// cbra_pkg: shared types and constants for the copy-on-write block remapper
// Action, status and classification codes, register map, reset values and
// the structs that travel between the front, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cbra_pkg;

  // default sizing of the count table and allocator
  localparam int unsigned DEF_TABLE_ENTRIES = 4096;
  localparam int unsigned DEF_SECTOR_BYTES  = 512;
  localparam int unsigned DEF_COUNT_WIDTH   = 16;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_LINEAR_DEV  = 3'd0;
  localparam logic [2:0] REG_FILEDATA    = 3'd1;
  localparam logic [2:0] REG_UNALLOC     = 3'd2;
  localparam logic [2:0] REG_CAPACITY    = 3'd3;
  localparam logic [2:0] REG_FIRST_BLOCK = 3'd4;
  localparam logic [2:0] REG_INIT_USED   = 3'd5;

  // register reset values
  localparam logic [7:0]  RST_LINEAR_DEV  = 8'd5;
  localparam logic [31:0] RST_FILEDATA    = 32'hffff_fffe;
  localparam logic [31:0] RST_UNALLOC     = 32'hffff_ffff;
  localparam logic [31:0] RST_CAPACITY    = 32'hffff_ffff;
  localparam logic [11:0] RST_FIRST_BLOCK = 12'd1;
  localparam logic [31:0] RST_INIT_USED   = 32'd512;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INC    = 2'd1,
    ACT_DEC    = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_CAPACITY = 2'd1,
    STAT_NO_TABLE = 2'd2,
    STAT_RANGE    = 2'd3
  } status_e;

  // what the back end has to do with a queued word
  typedef enum logic [2:0] {
    KIND_PASS         = 3'd0,
    KIND_ALLOC        = 3'd1,
    KIND_LOOKUP_RANGE = 3'd2,
    KIND_EXIST        = 3'd3,
    KIND_COUNT_RANGE  = 3'd4,
    KIND_INC          = 3'd5,
    KIND_DEC          = 3'd6,
    KIND_READ         = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] blk;
  } entry_t;

  typedef struct packed {
    logic [7:0]  linear_dev;
    logic [31:0] filedata;
    logic [31:0] unalloc;
    logic [31:0] capacity;
    logic [11:0] first_block;
    logic [31:0] init_used;
    logic        load_first;
    logic        load_used;
  } cfg_t;

endpackage

`default_nettype wire

### design/cow_block_remap_allocator.sv
// ----------------------------------------------------------------------------
// cow_block_remap_allocator: copy-on-write block remapper and allocator
// Per-block reference counts with a sequential block allocator.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (tuser = action, tdata = device id
//   and block number); one result word leaves on m_axis per request
//   (tuser = status, tdata = block out and count). Registers sit on the
//   APB port at byte address 4*index; pready is tied high.
//   A front stage classifies each word and drops it into a two-entry queue;
//   the back end runs it against the two-port count RAM (one write and
//   one registered read per cycle). Pass-through and range errors go from
//   S_IDLE straight to S_EMIT; count actions go through S_WAIT_A, fresh
//   allocations through S_WAIT_B, and a sharing break through both. The back
//   end holds one word at a time and pops the next only after emitting the last.
//   After reset the back end sweeps all TABLE_ENTRIES entries (4096 by
//   default), zeroing the count RAM; s_axis_tready stays low meanwhile,
//   register writes are still taken. A stalled m_axis holds its word; the
//   queue keeps filling until full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module cow_block_remap_allocator
  import cbra_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned SECTOR_BYTES  = DEF_SECTOR_BYTES,
  parameter int unsigned COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [7:0] device_id, [39:8] block_in
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] action
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,  // [31:0] block_out, [47:32] ref_count
  output logic      [1:0]  m_axis_tuser,  // [1:0] status
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  // configuration registers
  logic [7:0]  linear_dev_q;
  logic [31:0] filedata_q;
  logic [31:0] unalloc_q;
  logic [31:0] capacity_q;
  logic [11:0] first_block_q;
  logic [31:0] init_used_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  cfg_t        cfg;

  // front to queue to back
  logic                   fifo_push;
  entry_t                 fifo_in;
  logic                   fifo_full;
  logic                   fifo_pop;
  entry_t                 fifo_head;
  logic                   fifo_empty;
  logic                   clearing;

  // count RAM
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  // result
  status_e                res_status;
  logic [31:0]            res_block;
  logic [15:0]            res_count;

  // write on the access phase; no wait states
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_dev_q  <= RST_LINEAR_DEV;
      filedata_q    <= RST_FILEDATA;
      unalloc_q     <= RST_UNALLOC;
      capacity_q    <= RST_CAPACITY;
      first_block_q <= RST_FIRST_BLOCK;
      init_used_q   <= RST_INIT_USED;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LINEAR_DEV:  linear_dev_q  <= pwdata[7:0];
        REG_FILEDATA:    filedata_q    <= pwdata;
        REG_UNALLOC:     unalloc_q     <= pwdata;
        REG_CAPACITY:    capacity_q    <= pwdata;
        REG_FIRST_BLOCK: first_block_q <= pwdata[11:0];
        REG_INIT_USED:   init_used_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LINEAR_DEV:  prdata = {24'd0, linear_dev_q};
      REG_FILEDATA:    prdata = filedata_q;
      REG_UNALLOC:     prdata = unalloc_q;
      REG_CAPACITY:    prdata = capacity_q;
      REG_FIRST_BLOCK: prdata = {20'd0, first_block_q};
      REG_INIT_USED:   prdata = init_used_q;
      default:         prdata = '0;
    endcase
  end

  // writing first_block / initial_used_bytes also reloads the allocator
  always_comb begin
    cfg.linear_dev  = linear_dev_q;
    cfg.filedata    = filedata_q;
    cfg.unalloc     = unalloc_q;
    cfg.capacity    = capacity_q;
    cfg.first_block = pwdata[11:0];
    cfg.init_used   = pwdata;
    cfg.load_first  = cfg_we && (cfg_idx == REG_FIRST_BLOCK);
    cfg.load_used   = cfg_we && (cfg_idx == REG_INIT_USED);
  end

  cbra_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .action_i     (s_axis_tuser),
    .device_id_i  (s_axis_tdata[7:0]),
    .block_in_i   (s_axis_tdata[39:8]),
    .cfg_i        (cfg),
    .clearing_i   (clearing),
    .queue_full_i (fifo_full),
    .push_o       (fifo_push),
    .entry_o      (fifo_in)
  );

  cbra_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_in),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (fifo_head),
    .empty_o (fifo_empty)
  );

  cbra_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SECTOR_BYTES  (SECTOR_BYTES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (fifo_empty),
    .head_i      (fifo_head),
    .pop_o       (fifo_pop),
    .clearing_o  (clearing),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_status_o  (res_status),
    .m_block_o   (res_block),
    .m_count_o   (res_count)
  );

  cbra_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TABLE_ENTRIES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata = {res_count, res_block};
  assign m_axis_tuser = res_status;

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("request accepted during count table clear");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("back end popped an empty queue");

  a_write_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_waddr) < 32'(TABLE_ENTRIES)))
    else $error("count write outside the table");
`endif

endmodule

`default_nettype wire

### design/cbra_ram.sv
// ----------------------------------------------------------------------------
// cbra_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cbra_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/cbra_fifo.sv
// ----------------------------------------------------------------------------
// cbra_fifo: short queue between front and back end
// Holds classified words so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cbra_fifo #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d;
  logic [PW-1:0]    rd_q, rd_d;
  logic [CW-1:0]    fill_q, fill_d;

  assign full_o  = (fill_q == CW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + CW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### design/cbra_front.sv
// ----------------------------------------------------------------------------
// cbra_front: request intake and classification
// Accept a request word and sort it into the job the back end must run.
// ----------------------------------------------------------------------------
`default_nettype none

module cbra_front
  import cbra_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  device_id_i,
  input  wire logic [31:0] block_in_i,
  input  wire cfg_t        cfg_i,
  input  wire logic        clearing_i,
  input  wire logic        queue_full_i,
  output logic             push_o,
  output entry_t           entry_o
);

  logic    in_table;
  action_e action;

  assign action   = action_e'(action_i);
  assign in_table = block_in_i < 32'(TABLE_ENTRIES);
  assign ready_o  = !queue_full_i && !clearing_i;
  assign push_o   = valid_i && ready_o;

  always_comb begin
    entry_o.blk = block_in_i;
    unique case (action)
      ACT_LOOKUP: begin
        // the linear device or the file-data marker passes through; either beats unallocated
        if (device_id_i == cfg_i.linear_dev || block_in_i == cfg_i.filedata) begin
          entry_o.kind = KIND_PASS;
        end else if (block_in_i == cfg_i.unalloc) begin
          entry_o.kind = KIND_ALLOC;
        end else if (!in_table) begin
          entry_o.kind = KIND_LOOKUP_RANGE;
        end else begin
          entry_o.kind = KIND_EXIST;
        end
      end
      ACT_INC:  entry_o.kind = in_table ? KIND_INC  : KIND_COUNT_RANGE;
      ACT_DEC:  entry_o.kind = in_table ? KIND_DEC  : KIND_COUNT_RANGE;
      ACT_READ: entry_o.kind = in_table ? KIND_READ : KIND_COUNT_RANGE;
      default:  entry_o.kind = KIND_COUNT_RANGE;
    endcase
  end

endmodule

`default_nettype wire

### design/cbra_back.sv
// ----------------------------------------------------------------------------
// cbra_back: count table sequencer and block allocator
// Run queued jobs against the count RAM, hold the allocator state and
// drive the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbra_back
  import cbra_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned SECTOR_BYTES  = DEF_SECTOR_BYTES,
  parameter int unsigned COUNT_WIDTH   = DEF_COUNT_WIDTH,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES),
  localparam int unsigned NF_W  = ((IDX_W > 12) ? IDX_W : 12) + 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   empty_i,
  input  wire entry_t                 head_i,
  output logic                        pop_o,
  output logic                        clearing_o,
  output logic                        ram_we_o,
  output logic      [IDX_W-1:0]       ram_waddr_o,
  output logic      [COUNT_WIDTH-1:0] ram_wdata_o,
  output logic                        ram_re_o,
  output logic      [IDX_W-1:0]       ram_raddr_o,
  input  wire logic [COUNT_WIDTH-1:0] ram_rdata_i,
  output logic                        m_valid_o,
  input  wire logic                   m_ready_i,
  output status_e                     m_status_o,
  output logic      [31:0]            m_block_o,
  output logic      [15:0]            m_count_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WAIT_A,
    S_WAIT_B,
    S_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       clr_q, clr_d;
  entry_t                 cur_q, cur_d;
  logic [NF_W-1:0]        next_free_q, next_free_d;
  logic [31:0]            used_q, used_d;
  logic                   fwd_q, fwd_d;
  logic [COUNT_WIDTH-1:0] fwd_val_q, fwd_val_d;
  status_e                res_status_q, res_status_d;
  logic [31:0]            res_block_q, res_block_d;
  logic [COUNT_WIDTH-1:0] res_count_q, res_count_d;
  logic                   m_valid_q, m_valid_d;
  status_e                m_status_q, m_status_d;
  logic [31:0]            m_block_q, m_block_d;
  logic [15:0]            m_count_q, m_count_d;

  logic                   no_table;
  logic                   no_room;
  logic                   grab_ok;
  status_e                grab_fail;
  logic [IDX_W-1:0]       cur_idx;
  logic [IDX_W-1:0]       nf_idx;
  logic [COUNT_WIDTH-1:0] rd_val;
  logic [COUNT_WIDTH-1:0] rd_inc;
  logic [COUNT_WIDTH-1:0] rd_dec;
  logic [COUNT_WIDTH-1:0] b_val;
  logic [COUNT_WIDTH-1:0] b_inc;

  assign cur_idx = cur_q.blk[IDX_W-1:0];
  assign nf_idx  = next_free_q[IDX_W-1:0];

  // allocator check: table end first, then remaining byte capacity
  assign no_table  = next_free_q >= NF_W'(TABLE_ENTRIES);
  assign no_room   = (used_q > cfg_i.capacity) ||
                     ((cfg_i.capacity - used_q) < 32'(SECTOR_BYTES));
  assign grab_ok   = !no_table && !no_room;
  assign grab_fail = no_table ? STAT_NO_TABLE : STAT_CAPACITY;

  assign rd_val = ram_rdata_i;
  assign rd_inc = rd_val + COUNT_WIDTH'(1);
  assign rd_dec = rd_val - COUNT_WIDTH'(1);
  // the old block was written in the cycle the new one was read
  assign b_val  = fwd_q ? fwd_val_q : ram_rdata_i;
  assign b_inc  = b_val + COUNT_WIDTH'(1);

  assign clearing_o = (state_q == S_CLEAR);
  assign m_valid_o  = m_valid_q;
  assign m_status_o = m_status_q;
  assign m_block_o  = m_block_q;
  assign m_count_o  = m_count_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    next_free_d  = next_free_q;
    used_d       = used_q;
    fwd_d        = fwd_q;
    fwd_val_d    = fwd_val_q;
    res_status_d = res_status_q;
    res_block_d  = res_block_q;
    res_count_d  = res_count_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_block_d    = m_block_q;
    m_count_d    = m_count_q;
    pop_o        = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = cur_idx;
    ram_wdata_o  = '0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = cur_idx;

    if (m_valid_q && m_ready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          pop_o        = 1'b1;
          cur_d        = head_i;
          res_status_d = STAT_OK;
          res_block_d  = head_i.blk;
          res_count_d  = '0;
          fwd_d        = 1'b0;
          case (head_i.kind)
            KIND_PASS: begin
              state_d = S_EMIT;
            end
            KIND_LOOKUP_RANGE: begin
              res_status_d = STAT_RANGE;
              res_block_d  = cfg_i.unalloc;
              state_d      = S_EMIT;
            end
            KIND_COUNT_RANGE: begin
              res_status_d = STAT_RANGE;
              state_d      = S_EMIT;
            end
            KIND_ALLOC: begin
              if (grab_ok) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = nf_idx;
                state_d     = S_WAIT_B;
              end else begin
                res_status_d = grab_fail;
                res_block_d  = cfg_i.unalloc;
                state_d      = S_EMIT;
              end
            end
            default: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = head_i.blk[IDX_W-1:0];
              state_d     = S_WAIT_A;
            end
          endcase
        end
      end
      S_WAIT_A: begin
        case (cur_q.kind)
          KIND_INC: begin
            ram_we_o    = 1'b1;
            ram_wdata_o = rd_inc;
            res_count_d = rd_inc;
            state_d     = S_EMIT;
          end
          KIND_DEC: begin
            ram_we_o    = 1'b1;
            ram_wdata_o = rd_dec;
            res_count_d = rd_dec;
            state_d     = S_EMIT;
          end
          KIND_EXIST: begin
            if (rd_val > COUNT_WIDTH'(1)) begin
              // break sharing: drop the old count, then take a new block
              ram_we_o    = 1'b1;
              ram_wdata_o = rd_dec;
              if (grab_ok) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = nf_idx;
                fwd_d       = (next_free_q == NF_W'(cur_idx));
                fwd_val_d   = rd_dec;
                state_d     = S_WAIT_B;
              end else begin
                res_status_d = grab_fail;
                res_block_d  = cfg_i.unalloc;
                res_count_d  = rd_dec;
                state_d      = S_EMIT;
              end
            end else begin
              res_count_d = rd_val;
              state_d     = S_EMIT;
            end
          end
          default: begin
            res_count_d = rd_val;
            state_d     = S_EMIT;
          end
        endcase
      end
      S_WAIT_B: begin
        ram_we_o     = 1'b1;
        ram_waddr_o  = nf_idx;
        ram_wdata_o  = b_inc;
        res_status_d = STAT_OK;
        res_block_d  = 32'(next_free_q);
        res_count_d  = b_inc;
        next_free_d  = next_free_q + NF_W'(1);
        used_d       = used_q + 32'(SECTOR_BYTES);
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (!m_valid_q || m_ready_i) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_block_d  = res_block_q;
          m_count_d  = 16'(res_count_q);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_i.load_first) begin
      next_free_d = NF_W'(cfg_i.first_block);
    end
    if (cfg_i.load_used) begin
      used_d = cfg_i.init_used;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      cur_q        <= '0;
      next_free_q  <= NF_W'(RST_FIRST_BLOCK);
      used_q       <= RST_INIT_USED;
      fwd_q        <= 1'b0;
      fwd_val_q    <= '0;
      res_status_q <= STAT_OK;
      res_block_q  <= '0;
      res_count_q  <= '0;
      m_valid_q    <= 1'b0;
      m_status_q   <= STAT_OK;
      m_block_q    <= '0;
      m_count_q    <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cur_q        <= cur_d;
      next_free_q  <= next_free_d;
      used_q       <= used_d;
      fwd_q        <= fwd_d;
      fwd_val_q    <= fwd_val_d;
      res_status_q <= res_status_d;
      res_block_q  <= res_block_d;
      res_count_q  <= res_count_d;
      m_valid_q    <= m_valid_d;
      m_status_q   <= m_status_d;
      m_block_q    <= m_block_d;
      m_count_q    <= m_count_d;
    end
  end

endmodule

`default_nettype wire

### test/tb_cow_block_remap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cow_block_remap_allocator: self-checking bench for the COW block remapper
// Streams lookups and count actions through the block under several register
// settings. A scoreboard tracks the count table, the allocator and the byte
// budget, and checks every result word field by field, in order.
// ----------------------------------------------------------------------------

module tb_cow_block_remap_allocator;
  import cbra_pkg::*;

  localparam int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES;
  localparam int unsigned SECTOR_BYTES  = DEF_SECTOR_BYTES;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned IDLE_PCT      = 14;

  // one result word as it leaves on m_axis
  typedef struct packed {
    status_e     status;
    logic [31:0] block_out;
    logic [15:0] ref_count;
  } remap_word_t;

  // Mirrors the count table, the allocator and the registers; holds the
  // result words still owed by the block, oldest first.
  class cow_remap_tracker;
    logic [7:0]  linear_dev;
    logic [31:0] filedata;
    logic [31:0] unalloc;
    logic [31:0] capacity;
    logic [11:0] first_blk;
    logic [31:0] init_used;
    logic [15:0] counts [TABLE_ENTRIES];
    logic [12:0] next_free;
    logic [31:0] used_bytes;
    remap_word_t due_words [$];
    int unsigned errors;
    int unsigned requests;
    int unsigned grants;
    int unsigned splits;
    int unsigned short_space;
    int unsigned past_table;
    int unsigned ranges;

    function new();
      linear_dev = RST_LINEAR_DEV;
      filedata   = RST_FILEDATA;
      unalloc    = RST_UNALLOC;
      capacity   = RST_CAPACITY;
      first_blk  = RST_FIRST_BLOCK;
      init_used  = RST_INIT_USED;
      foreach (counts[i]) counts[i] = '0;
      next_free  = {1'b0, first_blk};
      used_bytes = init_used;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_LINEAR_DEV: linear_dev = val[7:0];
        REG_FILEDATA:   filedata = val;
        REG_UNALLOC:    unalloc = val;
        REG_CAPACITY:   capacity = val;
        REG_FIRST_BLOCK: begin
          first_blk = val[11:0];
          next_free = {1'b0, val[11:0]};
        end
        REG_INIT_USED: begin
          init_used  = val;
          used_bytes = val;
        end
        default: ;
      endcase
    endfunction

    // hand out the next block if the table and the byte budget allow it
    function status_e grant_block(output logic [31:0] blk);
      logic [31:0] room;
      blk = '0;
      if (next_free >= TABLE_ENTRIES) begin
        past_table++;
        return STAT_NO_TABLE;
      end
      room = (capacity >= used_bytes) ? capacity - used_bytes : 32'd0;
      if (room < SECTOR_BYTES) begin
        short_space++;
        return STAT_CAPACITY;
      end
      blk = {19'd0, next_free};
      counts[next_free[11:0]] = counts[next_free[11:0]] + 16'd1;
      next_free  = next_free + 13'd1;
      used_bytes = used_bytes + SECTOR_BYTES;
      grants++;
      return STAT_OK;
    endfunction

    // apply one accepted request and queue the word it must produce
    function void remap_request(action_e act, logic [7:0] dev, logic [31:0] blk);
      remap_word_t res;
      logic [31:0] nb;
      logic [11:0] ix;
      bit          in_tab;
      res.status    = STAT_OK;
      res.block_out = blk;
      res.ref_count = '0;
      ix     = blk[11:0];
      in_tab = blk < TABLE_ENTRIES;
      requests++;
      if (act == ACT_LOOKUP) begin
        if (dev == linear_dev || blk == filedata) begin
          // mapped one to one, nothing touched
        end else if (blk == unalloc) begin
          res.status = grant_block(nb);
          if (res.status == STAT_OK) begin
            res.block_out = nb;
            res.ref_count = counts[nb[11:0]];
          end else begin
            res.block_out = unalloc;
          end
        end else if (!in_tab) begin
          res.status    = STAT_RANGE;
          res.block_out = unalloc;
          ranges++;
        end else if (counts[ix] > 16'd1) begin
          // shared block: drop one reference, then copy to a fresh block;
          // the drop stays even when no block can be had
          splits++;
          counts[ix] = counts[ix] - 16'd1;
          res.status = grant_block(nb);
          if (res.status == STAT_OK) begin
            res.block_out = nb;
            res.ref_count = counts[nb[11:0]];
          end else begin
            res.block_out = unalloc;
            res.ref_count = counts[ix];
          end
        end else begin
          res.ref_count = counts[ix];
        end
      end else if (!in_tab) begin
        res.status = STAT_RANGE;
        ranges++;
      end else begin
        case (act)
          ACT_INC: counts[ix] = counts[ix] + 16'd1;
          ACT_DEC: counts[ix] = counts[ix] - 16'd1;
          default: ;
        endcase
        res.ref_count = counts[ix];
      end
      due_words.push_back(res);
    endfunction

    function void match_result(status_e st, logic [31:0] bout, logic [15:0] cnt);
      remap_word_t want;
      if (due_words.size() == 0) begin
        $error("result word with nothing outstanding: status %0d block %h count %0d",
               st, bout, cnt);
        errors++;
        return;
      end
      want = due_words.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (bout !== want.block_out) begin
        $error("block_out: expected %h, got %h", want.block_out, bout);
        errors++;
      end
      if (cnt !== want.ref_count) begin
        $error("ref_count: expected %0d, got %0d", want.ref_count, cnt);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_words.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [7:0] device_id, [39:8] block_in
  logic [1:0]  s_axis_tuser;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [31:0] block_out, [47:32] ref_count
  logic [1:0]  m_axis_tuser;   // [1:0] status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cow_remap_tracker tracker;
  bit               steady;       // suppress idling on both sides
  int unsigned      settings_run;

  cow_block_remap_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Result side: stall at random on the falling edge, check on the rising one.
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.match_result(status_e'(m_axis_tuser), m_axis_tdata[31:0],
                           m_axis_tdata[47:32]);
    end
  end

  // Bound the run; covers the table sweep after reset plus every stall.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("TEST FAILED");
    $finish;
  end

  // Offer one request word. Call at a falling edge; returns at a falling edge
  // with tvalid still high, so back-to-back words never drop it.
  task automatic send_word(action_e act, logic [7:0] dev, logic [31:0] blk);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blk, dev};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.remap_request(act, dev, blk);
    @(negedge clk_i);
  endtask

  // Hold the request side until every owed word is back, then let the
  // deepest pipeline path settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // One APB write: setup, then access. psel stays high so the next write can
  // follow directly; the caller releases the bus.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(logic [7:0] lin, logic [31:0] fd, logic [31:0] ua,
                               logic [31:0] cap, logic [11:0] fb, logic [31:0] iu);
    drain();
    write_reg(REG_LINEAR_DEV, {24'd0, lin});
    write_reg(REG_FILEDATA, fd);
    write_reg(REG_UNALLOC, ua);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_FIRST_BLOCK, {20'd0, fb});
    write_reg(REG_INIT_USED, iu);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [31:0] pick_marker();
    case ($urandom_range(3))
      0:       return 32'hffff_ffff;
      1:       return 32'hffff_fffe;
      2:       return $urandom_range(TABLE_ENTRIES - 1);
      default: return $urandom;
    endcase
  endfunction

  // block numbers that land on the interesting paths most of the time
  function automatic logic [31:0] noise_block();
    case ($urandom_range(6))
      0:       return $urandom;
      1:       return $urandom_range(TABLE_ENTRIES - 1);
      2:       return tracker.filedata;
      3:       return tracker.unalloc;
      4:       return TABLE_ENTRIES + $urandom_range(15);
      5:       return $urandom_range(1) ? 32'hffff_ffff : 32'd0;
      default: return {20'd0, tracker.next_free[11:0] - 12'd1 - 12'($urandom_range(7))};
    endcase
  endfunction

  // Mostly copy-on-write chains: allocate, share a few times, write through
  // the shared block, read back, maybe release. The rest is random noise.
  task automatic run_random(int unsigned n);
    int unsigned start;
    int unsigned hops;
    logic [7:0]  dev;
    logic [31:0] fresh;
    start = tracker.requests;
    while (tracker.requests - start < n) begin
      if ($urandom_range(99) < 70) begin
        dev = $urandom_range(255);
        if (dev == tracker.linear_dev) dev = dev ^ 8'h01;
        send_word(ACT_LOOKUP, dev, tracker.unalloc);
        fresh = {20'd0, tracker.next_free[11:0] - 12'd1};
        hops  = $urandom_range(3);
        repeat (hops) send_word(ACT_INC, 8'($urandom_range(255)), fresh);
        send_word(ACT_LOOKUP, dev, fresh);
        send_word(ACT_READ, 8'($urandom_range(255)), fresh);
        if ($urandom_range(1)) send_word(ACT_DEC, 8'($urandom_range(255)), fresh);
      end else begin
        dev = ($urandom_range(9) == 0) ? tracker.linear_dev : 8'($urandom_range(255));
        send_word(action_e'($urandom_range(3)), dev, noise_block());
      end
    end
  endtask

  initial begin
    tracker       = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    steady        = 1'b0;
    settings_run  = 1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_LOOKUP;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under reset register values. The first word waits out
    // the table sweep on tready.
    send_word(ACT_LOOKUP, 8'd5, 32'hffff_ffff);    // linear device beats markers
    send_word(ACT_LOOKUP, 8'd0, 32'hffff_fffe);    // file-data pass-through
    send_word(ACT_LOOKUP, 8'd0, 32'hffff_ffff);    // allocate block 1
    send_word(ACT_LOOKUP, 8'd255, 32'hffff_ffff);  // allocate block 2
    send_word(ACT_INC, 8'd0, 32'd1);
    send_word(ACT_LOOKUP, 8'd0, 32'd1);            // split shared block
    send_word(ACT_READ, 8'd0, 32'd1);
    send_word(ACT_LOOKUP, 8'd0, 32'd2);            // sole owner, unchanged
    send_word(ACT_LOOKUP, 8'd0, 32'd0);            // count zero, unchanged
    send_word(ACT_DEC, 8'd0, 32'd0);               // wrap below zero
    send_word(ACT_INC, 8'd0, 32'd0);               // wrap back to zero
    send_word(ACT_DEC, 8'd0, 32'd0);
    send_word(ACT_LOOKUP, 8'd1, 32'd0);            // split at the top count
    send_word(ACT_LOOKUP, 8'd0, 32'd4096);         // lookup past the table
    send_word(ACT_LOOKUP, 8'd0, 32'h1234_5678);
    send_word(ACT_INC, 8'd0, 32'd4096);            // count actions past the table
    send_word(ACT_DEC, 8'd0, 32'hffff_ffff);
    send_word(ACT_READ, 8'd0, 32'hffff_fffe);
    send_word(ACT_INC, 8'd0, 32'd4095);            // last table entry
    send_word(ACT_READ, 8'd255, 32'd4095);
    send_word(ACT_LOOKUP, 8'd0, 32'd4095);
    send_word(ACT_LOOKUP, 8'd5, 32'd4096);         // linear device skips range check

    // Random part over a spread of register settings; the extremes first.
    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: apply_setting(8'd0, 32'd0, 32'hffff_ffff, 32'hffff_ffff, 12'd0, 32'd0);
        // budget for forty sectors, then capacity misses
        2: apply_setting(8'd255, 32'hffff_ffff, 32'd0, 32'd20580, 12'd100, 32'd0);
        // no budget at all, markers inside the table
        3: apply_setting(8'($urandom_range(255)), $urandom_range(TABLE_ENTRIES - 1),
                         $urandom_range(TABLE_ENTRIES - 1), 32'd0, 12'd4095,
                         32'hffff_ffff);
        // run off the end of the table
        4: apply_setting(8'd5, 32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff, 12'd4080,
                         $urandom_range(1 << 20));
        default: apply_setting(8'($urandom_range(255)), pick_marker(), pick_marker(),
                               ($urandom_range(2) == 0) ?
                                 32'(SECTOR_BYTES * $urandom_range(1, 64)
                                     + $urandom_range(SECTOR_BYTES - 1)) :
                                 32'hffff_ffff,
                               ($urandom_range(3) == 0) ? 12'($urandom_range(4095)) :
                                                          12'($urandom_range(200)),
                               $urandom_range(1) ? 32'($urandom) :
                                                   32'($urandom_range(1 << 16)));
      endcase
      steady = (p == 5);
      if (p == 6) begin
        // hold the sender mid-stream until the result side has caught up
        run_random(95);
        drain();
        run_random(95);
      end else begin
        run_random(190);
      end
    end
    steady = 1'b0;

    drain();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d requests under %0d register settings.",
             tracker.requests, settings_run);
    $display("Saw %0d grants, %0d shared-block splits, %0d budget misses, %0d table overruns, %0d range errors.",
             tracker.grants, tracker.splits, tracker.short_space, tracker.past_table,
             tracker.ranges);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
